### rtl/lfpa_pkg.sv
// ----------------------------------------------------------------------------
// lfpa_pkg
// Shared constants, codes and controller/datapath signal groups for the
// range-sensor frame parser and distance averager.
// ----------------------------------------------------------------------------
package lfpa_pkg;

  localparam int CFG_W      = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int SUM_W      = 25;
  localparam int CNT_W      = 10;
  localparam int FRAC_W     = 8;
  localparam int DIST_W     = 24;
  localparam int DVD_W      = SUM_W + FRAC_W;
  localparam int DIV_STEPS  = DVD_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  localparam logic [CNT_W-1:0]     COUNT_LIMIT = CNT_W'(1023);
  localparam logic [7:0]           HDR_BYTE    = 8'h59;
  localparam logic [7:0]           SIG_MIN     = 8'd7;
  localparam logic [CFG_W:0]       OOR_ADD_CM  = (CFG_W + 1)'(100);
  localparam logic [CFG_W-1:0]     MODEL_MAX_RST = CFG_W'(1200);
  localparam logic [CFG_W-1:0]     USER_MAX_RST  = CFG_W'(1200);

  localparam logic [CFG_IDX_W-1:0] CFG_MODEL_MAX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIG_CHECK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_USER_MAX  = 2'd2;

  localparam logic [3:0] POS_HDR0  = 4'd0;
  localparam logic [3:0] POS_HDR1  = 4'd1;
  localparam logic [3:0] POS_DLO   = 4'd2;
  localparam logic [3:0] POS_DHI   = 4'd3;
  localparam logic [3:0] POS_SIG   = 4'd6;
  localparam logic [3:0] POS_CSUM  = 4'd8;

  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_READOUT = 1'b1;

  typedef enum logic [1:0] {
    STATUS_NONE = 2'd0,
    STATUS_AVG  = 2'd1,
    STATUS_OOR  = 2'd2
  } status_t;

  typedef struct packed {
    logic take_byte;
    logic readout;
    logic div_finish;
  } lfpa_cmd_t;

  typedef struct packed {
    logic good_nz;
    logic div_done;
  } lfpa_sts_t;

endpackage

### rtl/lfpa_div.sv
// ----------------------------------------------------------------------------
// lfpa_div
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lfpa_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [lfpa_pkg::DVD_W-1:0]   dividend,
  input  logic [lfpa_pkg::CNT_W-1:0]   divisor,
  output logic                         done,
  output logic [lfpa_pkg::DIST_W-1:0]  quotient
);
  import lfpa_pkg::*;

  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;
  logic [DVD_W-1:0]     dvd_r, dvd_nxt;
  logic [CNT_W:0]       rem_r, rem_nxt;
  logic [CNT_W:0]       rem_sh;
  logic [CNT_W:0]       rem_sub;
  logic [CNT_W-1:0]     dsr_r;
  logic                 qbit;

  assign rem_sh  = {rem_r[CNT_W-1:0], dvd_r[DVD_W-1]};
  assign qbit    = (rem_sh >= {1'b0, dsr_r});
  assign rem_sub = rem_sh - {1'b0, dsr_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt = DIV_CNT_W'(DIV_STEPS);
      dvd_nxt = dividend;
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - DIV_CNT_W'(1);
      dvd_nxt  = {dvd_r[DVD_W-2:0], qbit};
      rem_nxt  = qbit ? rem_sub : rem_sh;
      done_nxt = (cnt_r == DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dsr_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r[DIST_W-1:0];

endmodule

### rtl/lfpa_datapath.sv
// ----------------------------------------------------------------------------
// lfpa_datapath
// Frame parser, checksum and classification, saturating counters, distance
// sum, configuration registers, divider and result register.
// ----------------------------------------------------------------------------
module lfpa_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lfpa_pkg::lfpa_cmd_t              cmd,
  output lfpa_pkg::lfpa_sts_t              sts,
  input  logic [7:0]                       data_byte,
  input  logic                             cfg_we,
  input  logic [lfpa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lfpa_pkg::CFG_W-1:0]       cfg_wdata,
  output logic [1:0]                       status,
  output logic [lfpa_pkg::DIST_W-1:0]      distance_q8
);
  import lfpa_pkg::*;

  logic [CFG_W-1:0] model_max_r;
  logic             sig_check_r;
  logic [CFG_W-1:0] user_max_r;

  logic [3:0]       pos_r, pos_nxt;
  logic [7:0]       csum_r, csum_nxt;
  logic [7:0]       dlo_r, dhi_r, sig_r;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] good_r, good_nxt;
  logic [CNT_W-1:0] bad_r, bad_nxt;

  logic [CFG_W-1:0] frame_dist;
  logic             frame_end;
  logic             csum_ok;
  logic             out_range;
  logic             sig_fail;
  logic             good_nz;
  logic [CFG_W:0]   user_plus;
  logic [CFG_W:0]   oor_cm;
  logic [1:0]       direct_status;
  logic [DIST_W-1:0] direct_dist;

  logic [1:0]        status_r;
  logic [DIST_W-1:0] dist_r;

  logic              div_done;
  logic [DIST_W-1:0] div_q;

  assign frame_dist = {dhi_r[6:0], dlo_r};
  assign frame_end  = cmd.take_byte && (pos_r == POS_CSUM);
  assign csum_ok    = (data_byte == csum_r);
  assign out_range  = dhi_r[7] || (frame_dist == model_max_r);
  assign sig_fail   = sig_check_r && (sig_r < SIG_MIN);
  assign good_nz    = (good_r != '0);

  assign user_plus = {1'b0, user_max_r} + OOR_ADD_CM;
  assign oor_cm    = ({1'b0, model_max_r} > user_plus) ? {1'b0, model_max_r} : user_plus;

  always_comb begin
    direct_status = STATUS_NONE;
    direct_dist   = '0;
    if (bad_r != '0) begin
      direct_status = STATUS_OOR;
      direct_dist   = DIST_W'({oor_cm, {FRAC_W{1'b0}}});
    end
  end

  always_comb begin
    pos_nxt  = pos_r;
    csum_nxt = csum_r;
    if (cmd.take_byte) begin
      priority case (1'b1)
        pos_r == POS_HDR0: begin
          if (data_byte == HDR_BYTE) begin
            csum_nxt = data_byte;
            pos_nxt  = POS_HDR1;
          end
        end
        pos_r == POS_HDR1: begin
          if (data_byte == HDR_BYTE) begin
            csum_nxt = csum_r + data_byte;
            pos_nxt  = POS_DLO;
          end else begin
            pos_nxt = POS_HDR0;
          end
        end
        pos_r < POS_CSUM: begin
          csum_nxt = csum_r + data_byte;
          pos_nxt  = pos_r + 4'd1;
        end
        default: begin
          pos_nxt = POS_HDR0;
        end
      endcase
    end
  end

  always_comb begin
    sum_nxt  = sum_r;
    good_nxt = good_r;
    bad_nxt  = bad_r;
    if (cmd.readout) begin
      sum_nxt  = '0;
      good_nxt = '0;
      bad_nxt  = '0;
    end else if (frame_end && csum_ok) begin
      if (out_range || sig_fail) begin
        if (bad_r < COUNT_LIMIT) begin
          bad_nxt = bad_r + CNT_W'(1);
        end
      end else if (good_r < COUNT_LIMIT) begin
        sum_nxt  = sum_r + SUM_W'(frame_dist);
        good_nxt = good_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      model_max_r <= MODEL_MAX_RST;
      sig_check_r <= 1'b0;
      user_max_r  <= USER_MAX_RST;
      pos_r       <= POS_HDR0;
      csum_r      <= '0;
      dlo_r       <= '0;
      dhi_r       <= '0;
      sig_r       <= '0;
      sum_r       <= '0;
      good_r      <= '0;
      bad_r       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MODEL_MAX: model_max_r <= cfg_wdata;
          CFG_SIG_CHECK: sig_check_r <= cfg_wdata[0];
          CFG_USER_MAX:  user_max_r  <= cfg_wdata;
          default: ;
        endcase
      end
      pos_r  <= pos_nxt;
      csum_r <= csum_nxt;
      if (cmd.take_byte && pos_r == POS_DLO) dlo_r <= data_byte;
      if (cmd.take_byte && pos_r == POS_DHI) dhi_r <= data_byte;
      if (cmd.take_byte && pos_r == POS_SIG) sig_r <= data_byte;
      sum_r  <= sum_nxt;
      good_r <= good_nxt;
      bad_r  <= bad_nxt;
    end
  end

  lfpa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.readout && good_nz),
    .dividend ({sum_r, {FRAC_W{1'b0}}}),
    .divisor  (good_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_finish) begin
      status_r <= STATUS_AVG;
      dist_r   <= div_q;
    end else if (cmd.readout && !good_nz) begin
      status_r <= direct_status;
      dist_r   <= direct_dist;
    end
  end

  assign sts.good_nz  = good_nz;
  assign sts.div_done = div_done;
  assign status       = status_r;
  assign distance_q8  = dist_r;

endmodule

### rtl/lfpa_ctrl.sv
// ----------------------------------------------------------------------------
// lfpa_ctrl
// Handshake and sequencing controller: accepts transactions, waits out the
// divider and owns the result valid flag.
// ----------------------------------------------------------------------------
module lfpa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_cmd,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lfpa_pkg::lfpa_cmd_t  cmd,
  input  lfpa_pkg::lfpa_sts_t  sts
);
  import lfpa_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   acc;

  assign in_ready = (state_r == ST_IDLE) && !(in_cmd == CMD_READOUT && out_valid_r);
  assign acc      = in_valid && in_ready;

  assign cmd.take_byte  = acc && (in_cmd == CMD_BYTE);
  assign cmd.readout    = acc && (in_cmd == CMD_READOUT);
  assign cmd.div_finish = (state_r == ST_DIV) && sts.div_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (cmd.readout) begin
            if (sts.good_nz) begin
              state_r <= ST_DIV;
            end else begin
              out_valid_r <= 1'b1;
            end
          end
        end
        ST_DIV: begin
          if (sts.div_done) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/lidar_frame_parser_averager.sv
// ----------------------------------------------------------------------------
// lidar_frame_parser_averager
// Serial range-sensor frame parser with checksum check and distance averaging.
// ----------------------------------------------------------------------------
// Serial bytes (cmd 0) are taken one per clock while no division runs and never
// produce a result. A readout (cmd 1) produces one result: with no good frames
// pending it is ready the cycle after acceptance; with good frames it waits on
// the bit-serial restoring divider, which forms one of 33 quotient bits per
// cycle, and no transaction is accepted while it runs. A readout is held off
// while the previous result still waits on the output; serial bytes are not.
module lidar_frame_parser_averager (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_cmd,
  input  logic [7:0]                      in_data_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_status,
  output logic [lfpa_pkg::DIST_W-1:0]     out_distance_q8,
  input  logic                            cfg_we,
  input  logic [lfpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lfpa_pkg::CFG_W-1:0]      cfg_wdata
);
  import lfpa_pkg::*;

  lfpa_cmd_t ctrl_cmd;
  lfpa_sts_t dp_sts;

  lfpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (ctrl_cmd),
    .sts       (dp_sts)
  );

  lfpa_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (ctrl_cmd),
    .sts         (dp_sts),
    .data_byte   (in_data_byte),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .status      (out_status),
    .distance_q8 (out_distance_q8)
  );

`ifndef ASSERT_OFF
  a_readout_needs_free_out: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.readout |-> !out_valid)
    else $error("readout accepted while a result is pending");

  a_div_done_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.div_finish |=> (out_valid && out_status == STATUS_AVG))
    else $error("divider finish did not present an average");

  a_busy_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl_cmd.readout && dp_sts.good_nz) |=> !in_ready)
    else $error("input accepted while divider runs");
`endif

endmodule

### test/lidar_frame_parser_averager_chk.sv
// ----------------------------------------------------------------------------
// lidar_frame_parser_averager_chk
// Scoreboard for the range-sensor frame parser and distance averager.
// Follows every configuration write and input transaction. It keeps its own
// copy of the frame parser and the accumulators, queues the reading that
// each readout should produce, and compares every output transaction with the
// oldest queued reading, field by field.
// ----------------------------------------------------------------------------
module lidar_frame_parser_averager_chk (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_cmd,
  input  logic [7:0]                     in_data_byte,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [1:0]                     out_status,
  input  logic [lfpa_pkg::DIST_W-1:0]    out_distance_q8,
  input  logic                           cfg_we,
  input  logic [lfpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lfpa_pkg::CFG_W-1:0]     cfg_wdata,
  output int                             fail_count,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import lfpa_pkg::*;

  typedef struct packed {
    status_t           status;
    logic [DIST_W-1:0] dist_q8;
  } reading_t;

  reading_t readings_due[$];

  logic [CFG_W-1:0] model_max;
  logic             sig_check;
  logic [CFG_W-1:0] user_max;

  logic [3:0]       frame_pos;
  logic [7:0]       frame_sum;
  logic [7:0]       dist_lo;
  logic [7:0]       dist_hi;
  logic [7:0]       sig_level;
  logic [SUM_W-1:0] dist_acc;
  logic [CNT_W-1:0] good_n;
  logic [CNT_W-1:0] oor_n;

  function automatic void count_oor();
    if (oor_n < COUNT_LIMIT) oor_n = oor_n + 1'b1;
  endfunction

  function automatic void close_frame();
    logic [15:0] d;
    d = {dist_hi, dist_lo};
    if (d[15] || d == {1'b0, model_max}) begin
      count_oor();
    end else if (sig_check && sig_level < SIG_MIN) begin
      count_oor();
    end else if (good_n < COUNT_LIMIT) begin
      dist_acc = dist_acc + SUM_W'(d);
      good_n = good_n + 1'b1;
    end
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    if (frame_pos == POS_HDR0) begin
      if (b == HDR_BYTE) begin
        frame_sum = b;
        frame_pos = POS_HDR1;
      end
    end else if (frame_pos == POS_HDR1) begin
      if (b == HDR_BYTE) begin
        frame_sum = frame_sum + b;
        frame_pos = POS_DLO;
      end else begin
        frame_pos = POS_HDR0;
      end
    end else if (frame_pos < POS_CSUM) begin
      if (frame_pos == POS_DLO) dist_lo = b;
      if (frame_pos == POS_DHI) dist_hi = b;
      if (frame_pos == POS_SIG) sig_level = b;
      frame_sum = frame_sum + b;
      frame_pos = frame_pos + 1'b1;
    end else begin
      if (b == frame_sum) close_frame();
      frame_pos = POS_HDR0;
    end
  endfunction

  function automatic reading_t take_readout();
    reading_t         r;
    logic [DVD_W-1:0] scaled;
    logic [CFG_W:0]   raised;
    r.status = STATUS_NONE;
    r.dist_q8 = '0;
    if (good_n != 0) begin
      scaled = {dist_acc, {FRAC_W{1'b0}}};
      scaled = scaled / DVD_W'(good_n);
      r.status = STATUS_AVG;
      r.dist_q8 = scaled[DIST_W-1:0];
    end else if (oor_n != 0) begin
      raised = {1'b0, user_max} + OOR_ADD_CM;
      if ({1'b0, model_max} > raised) raised = {1'b0, model_max};
      r.status = STATUS_OOR;
      r.dist_q8 = {raised, {FRAC_W{1'b0}}};
    end
    dist_acc = '0;
    good_n = '0;
    oor_n = '0;
    return r;
  endfunction

  function automatic void check_reading(input logic [1:0] st, input logic [DIST_W-1:0] d);
    reading_t r;
    if (readings_due.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected reading, expected none, got status %0d distance %0d",
               $realtime, st, d);
    end else begin
      r = readings_due.pop_front();
      if (st != r.status) begin
        fail_count++;
        $display("%0t: status expected %0d got %0d", $realtime, r.status, st);
      end
      if (d != r.dist_q8) begin
        fail_count++;
        $display("%0t: distance_q8 expected %0d got %0d", $realtime, r.dist_q8, d);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      model_max = MODEL_MAX_RST;
      sig_check = 1'b0;
      user_max = USER_MAX_RST;
      frame_pos = POS_HDR0;
      frame_sum = '0;
      dist_lo = '0;
      dist_hi = '0;
      sig_level = '0;
      dist_acc = '0;
      good_n = '0;
      oor_n = '0;
      readings_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODEL_MAX: model_max = cfg_wdata;
          CFG_SIG_CHECK: sig_check = cfg_wdata[0];
          CFG_USER_MAX:  user_max = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) check_reading(out_status, out_distance_q8);
      if (in_valid && in_ready) begin
        if (in_cmd == CMD_READOUT) readings_due.push_back(take_readout());
        else parse_byte(in_data_byte);
      end
    end
    pending = readings_due.size();
  end

endmodule

### test/lidar_frame_parser_averager_tb.sv
// ----------------------------------------------------------------------------
// lidar_frame_parser_averager_tb
// Stimulus and verdict for the range-sensor frame parser and distance averager.
// Runs directed frames covering range limits, checksum errors, header resync,
// signal-level checks and the out-of-range report. It then runs random phases
// of well-formed frames mixed with broken ones, noise and readouts. Both sides
// idle at random, and the scoreboard module checks every output reading.
// ----------------------------------------------------------------------------
module lidar_frame_parser_averager_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lfpa_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT   = 3000;
  localparam int RANDOM_ITEMS  = 1800;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_cmd;
  logic [7:0]           in_data_byte;
  logic                 out_valid;
  logic                 out_ready;
  logic [1:0]           out_status;
  logic [DIST_W-1:0]    out_distance_q8;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  int               check_fails;
  int               readings_pending;
  int               quiet_cycles;
  int               sent_items;
  int               mixed_items;
  int               phase_no;
  int               start_items;
  bit               steady;
  logic [CFG_W-1:0] model_now;

  lidar_frame_parser_averager u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_distance_q8 (out_distance_q8),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  lidar_frame_parser_averager_chk u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_distance_q8 (out_distance_q8),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (check_fails),
    .pending         (readings_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL lidar_frame_parser_averager");
      $finish;
    end
  end

  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      stall = (steady || $urandom_range(0, 1)) ? 0 : $urandom_range(1, 12);
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  task automatic send_item(input logic cmd, input logic [7:0] data);
    int gap;
    gap = (steady || $urandom_range(0, 1)) ? 0 : $urandom_range(1, 12);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_data_byte <= data;
    do @(posedge clk); while (!in_ready);
    sent_items++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(CMD_BYTE, b);
  endtask

  task automatic read_out();
    send_item(CMD_READOUT, 8'($urandom));
  endtask

  task automatic send_frame(input logic [15:0] frame_dist, input logic [7:0] sig,
                            input bit spoil, input bit interleave);
    logic [7:0] frame [9];
    logic [7:0] sum;
    frame[0] = HDR_BYTE;
    frame[1] = HDR_BYTE;
    frame[2] = frame_dist[7:0];
    frame[3] = frame_dist[15:8];
    frame[4] = 8'($urandom);
    frame[5] = 8'($urandom);
    frame[6] = sig;
    frame[7] = 8'($urandom);
    sum = '0;
    for (int i = 0; i < 8; i++) sum = sum + frame[i];
    frame[8] = spoil ? sum ^ (8'd1 << $urandom_range(0, 7)) : sum;
    for (int i = 0; i < 9; i++) begin
      if (interleave && $urandom_range(0, 29) == 0) read_out();
      send_byte(frame[i]);
    end
  endtask

  // drop valid and let the block drain before touching the registers
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (readings_pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] model, input logic sig,
                            input logic [CFG_W-1:0] user);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MODEL_MAX;
    cfg_wdata <= model;
    @(negedge clk);
    cfg_index <= CFG_SIG_CHECK;
    cfg_wdata <= CFG_W'(sig);
    @(negedge clk);
    cfg_index <= CFG_USER_MAX;
    cfg_wdata <= user;
    @(negedge clk);
    cfg_we <= 1'b0;
    model_now = model;
  endtask

  function automatic logic [CFG_W-1:0] pick_limit();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return CFG_W'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_distance();
    case ($urandom_range(0, 5))
      0:       return {1'b0, model_now};
      1:       return 16'($urandom);
      2:       return {1'b1, 15'($urandom)};
      3:       return 16'($urandom_range(0, 15));
      4:       return {1'b0, 15'($urandom)};
      default: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    endcase
  endfunction

  function automatic logic [7:0] pick_signal();
    return $urandom_range(0, 1) ? 8'($urandom_range(0, 14)) : 8'($urandom);
  endfunction

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_BYTE;
    in_data_byte = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_MODEL_MAX;
    cfg_wdata = '0;
    steady = 1'b0;
    sent_items = 0;
    mixed_items = 0;
    phase_no = 0;
    model_now = MODEL_MAX_RST;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    read_out();
    send_frame(16'd0, 8'd0, 1'b0, 1'b0);
    send_frame(16'd32767, 8'd255, 1'b0, 1'b0);
    read_out();
    send_frame(16'(MODEL_MAX_RST), 8'd100, 1'b0, 1'b0);
    read_out();
    send_frame(16'h8000, 8'd100, 1'b0, 1'b0);
    send_frame(16'hFFFF, 8'd100, 1'b0, 1'b0);
    send_frame(16'd5, 8'd100, 1'b1, 1'b0);
    read_out();
    send_frame(16'd5, 8'd100, 1'b1, 1'b0);
    read_out();
    send_byte(HDR_BYTE);
    send_byte(8'hA6);
    send_byte(HDR_BYTE);
    send_byte(HDR_BYTE);
    send_byte(8'd77);
    read_out();
    send_frame(16'd77, 8'd1, 1'b0, 1'b0);
    read_out();

    settle();
    set_config('0, 1'b1, '1);
    send_frame(16'd0, 8'd200, 1'b0, 1'b0);
    send_frame(16'd10, 8'd6, 1'b0, 1'b0);
    read_out();
    send_frame(16'd10, 8'd7, 1'b0, 1'b0);
    send_frame(16'd11, 8'd255, 1'b0, 1'b0);
    read_out();
    settle();
    set_config('1, 1'b0, '0);
    send_frame(16'd32767, 8'd0, 1'b0, 1'b0);
    read_out();

    while (mixed_items < RANDOM_ITEMS || phase_no < 6) begin
      phase_no++;
      settle();
      set_config(pick_limit(), 1'($urandom_range(0, 1)), pick_limit());
      steady = ($urandom_range(0, 3) == 0);
      start_items = sent_items;
      repeat ($urandom_range(1, 30)) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: send_frame(pick_distance(), pick_signal(), 1'b0, 1'b1);
          6: send_frame(pick_distance(), pick_signal(), 1'b1, 1'b1);
          7: begin
            send_byte(HDR_BYTE);
            send_byte(8'($urandom));
          end
          8: repeat ($urandom_range(1, 6)) begin
            send_byte($urandom_range(0, 1) ? HDR_BYTE : 8'($urandom));
          end
          default: read_out();
        endcase
      end
      mixed_items += sent_items - start_items;
    end

    steady = 1'b0;
    settle();
    if (check_fails == 0 && readings_pending == 0) begin
      $display("PASS lidar_frame_parser_averager");
    end else begin
      $display("FAIL lidar_frame_parser_averager");
    end
    $finish;
  end

endmodule
